### hdl/iso_fletcher_checkbyte_generator_core_defines.svh
// Assertion macros used by the checksum generator queue.
`ifndef ISO_FLETCHER_CHECKBYTE_GENERATOR_CORE_DEFINES_SVH
`define ISO_FLETCHER_CHECKBYTE_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define FCGEN_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fcgen same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define FCGEN_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fcgen next-cycle check failed");

`endif

### hdl/fcgen_pkg.sv
package fcgen_pkg;

    // Modulus of both running sums.
    localparam int MOD = 255;
    // Byte count at which the message length saturates.
    localparam logic [15:0] MAX_LEN = 16'hFFFF;
    // Reset value of the checksum offset register.
    localparam logic [15:0] OFFSET_RESET = 16'd14;
    // Depth of the queue between accumulator and finisher.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Finished message summary handed from the front to the back.
    typedef struct packed {
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] n_mod;
        logic [7:0] k_mod;
    } sums_t;

    // Reduce a value below 2*255+1 to its residue modulo 255.
    function automatic logic [7:0] red9(input logic [8:0] v);
        logic [8:0] r;
        if (v >= 9'(2 * MOD)) begin
            r = v - 9'(2 * MOD);
        end else if (v >= 9'(MOD)) begin
            r = v - 9'(MOD);
        end else begin
            r = v;
        end
        return r[7:0];
    endfunction

    // Residue of a 16-bit value modulo 255 (256 is congruent to 1).
    function automatic logic [7:0] red16(input logic [15:0] v);
        logic [8:0] s;
        s = {1'b0, v[15:8]} + {1'b0, v[7:0]};
        return red9(s);
    endfunction

    // A zero check byte is sent as 255.
    function automatic logic [7:0] fix_zero(input logic [7:0] v);
        return (v == 8'd0) ? 8'hFF : v;
    endfunction

endpackage

### hdl/fcgen_front.sv
module fcgen_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                q_room,
    output logic                q_push,
    output fcgen_pkg::sums_t    q_data
);

    logic [15:0] offset_reg, offset_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  cnt_mod_reg, cnt_mod_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;

    logic        accept;
    logic        active;
    logic        blank;
    logic [7:0]  byte_eff;
    logic [7:0]  upd_a, upd_b, upd_mod;
    logic [15:0] upd_cnt;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_room;
    assign accept    = in_valid && in_ready;
    assign q_push    = accept && in_last;

    // Counting stops at the length limit; the two check-byte positions add zero.
    always_comb begin
        active   = (cnt_reg != fcgen_pkg::MAX_LEN);
        blank    = (cnt_reg == offset_reg) ||
                   ({1'b0, cnt_reg} == ({1'b0, offset_reg} + 17'd1));
        byte_eff = blank ? 8'd0 : in_byte;
        if (active) begin
            upd_a   = fcgen_pkg::red9({1'b0, sum_a_reg} + {1'b0, byte_eff});
            upd_b   = fcgen_pkg::red9({1'b0, sum_b_reg} + {1'b0, upd_a});
            upd_cnt = cnt_reg + 16'd1;
            upd_mod = (cnt_mod_reg == 8'(fcgen_pkg::MOD - 1)) ? 8'd0 : cnt_mod_reg + 8'd1;
        end else begin
            upd_a   = sum_a_reg;
            upd_b   = sum_b_reg;
            upd_cnt = cnt_reg;
            upd_mod = cnt_mod_reg;
        end
    end

    // Summary of the message that ends with this item.
    always_comb begin
        q_data.sum_a = upd_a;
        q_data.sum_b = upd_b;
        q_data.n_mod = upd_mod;
        q_data.k_mod = fcgen_pkg::red16(offset_reg);
    end

    // Next state: update on each item, clear after the last one.
    always_comb begin
        offset_next  = (cfg_valid && cfg_ready) ? cfg_data : offset_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        cnt_next     = cnt_reg;
        cnt_mod_next = cnt_mod_reg;
        if (accept) begin
            if (in_last) begin
                sum_a_next   = 8'd0;
                sum_b_next   = 8'd0;
                cnt_next     = 16'd0;
                cnt_mod_next = 8'd0;
            end else begin
                sum_a_next   = upd_a;
                sum_b_next   = upd_b;
                cnt_next     = upd_cnt;
                cnt_mod_next = upd_mod;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= fcgen_pkg::OFFSET_RESET;
            sum_a_reg   <= 8'd0;
            sum_b_reg   <= 8'd0;
            cnt_reg     <= 16'd0;
            cnt_mod_reg <= 8'd0;
        end else begin
            offset_reg  <= offset_next;
            sum_a_reg   <= sum_a_next;
            sum_b_reg   <= sum_b_next;
            cnt_reg     <= cnt_next;
            cnt_mod_reg <= cnt_mod_next;
        end
    end

endmodule

### hdl/fcgen_queue.sv
`include "iso_fletcher_checkbyte_generator_core_defines.svh"

module fcgen_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  fcgen_pkg::sums_t    push_data,
    output logic                room,
    input  logic                pop,
    output logic                head_valid,
    output fcgen_pkg::sums_t    head_data
);

    fcgen_pkg::sums_t                   entry_reg [fcgen_pkg::QUEUE_DEPTH];
    logic [fcgen_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fcgen_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fcgen_pkg::QUEUE_CW-1:0]     count_reg, count_next;

    assign room       = (count_reg != fcgen_pkg::QUEUE_CW'(fcgen_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == fcgen_pkg::QUEUE_AW'(fcgen_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == fcgen_pkg::QUEUE_AW'(fcgen_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // A push never lands on a full queue, and a pop never takes from an empty one.
    `FCGEN_ASSERT_NOW(a_no_push_full, aclk, aresetn, push, room)
    `FCGEN_ASSERT_NOW(a_no_pop_empty, aclk, aresetn, pop, head_valid)
    // A lone push grows the fill count by one.
    `FCGEN_ASSERT_NEXT(a_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

### hdl/fcgen_back.sv
module fcgen_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  fcgen_pkg::sums_t    q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         out_word
);

    logic        s1_valid_reg, s1_valid_next;
    logic [15:0] prod_x_reg;
    logic [15:0] prod_y_reg;
    logic [7:0]  s1_sum_b_reg;
    logic        o_valid_reg, o_valid_next;
    logic [15:0] o_word_reg;

    logic        s1_ready, o_ready;
    logic [7:0]  d, dm1;
    logic [7:0]  rx, ry, x, y;

    assign o_ready  = !o_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || o_ready;
    assign q_pop    = q_valid && s1_ready;

    // Stage one: d = (n - k) mod 255 and the two products with sum_a.
    always_comb begin
        d   = fcgen_pkg::red9({1'b0, q_data.n_mod} + 9'(fcgen_pkg::MOD) - {1'b0, q_data.k_mod});
        dm1 = (d == 8'd0) ? 8'(fcgen_pkg::MOD - 1) : d - 8'd1;
    end

    // Stage two: reduce the products and form both check bytes.
    always_comb begin
        rx = fcgen_pkg::red16(prod_x_reg);
        ry = fcgen_pkg::red16(prod_y_reg);
        x  = fcgen_pkg::fix_zero(fcgen_pkg::red9({1'b0, rx} + 9'(fcgen_pkg::MOD) -
                                                 {1'b0, s1_sum_b_reg}));
        y  = fcgen_pkg::fix_zero(fcgen_pkg::red9({1'b0, s1_sum_b_reg} + 9'(fcgen_pkg::MOD) -
                                                 {1'b0, ry}));
    end

    // Valid flags advance where the next stage is free or being drained.
    always_comb begin
        s1_valid_next = s1_ready ? q_valid : s1_valid_reg;
        o_valid_next  = o_ready ? s1_valid_reg : o_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            prod_x_reg   <= dm1 * q_data.sum_a;
            prod_y_reg   <= d * q_data.sum_a;
            s1_sum_b_reg <= q_data.sum_b;
        end
        if (o_ready) begin
            o_word_reg <= {x, y};
        end
    end

    assign out_valid = o_valid_reg;
    assign out_word  = o_word_reg;

endmodule

### hdl/iso_fletcher_checkbyte_generator_core.sv
// ISO 8473 Fletcher check-byte generator.
// The s_ channel carries message bytes: s_tdata is the byte, s_tlast marks
// the final byte of a message. One byte is taken per cycle while the
// internal queue has room. After each last byte one item leaves on the
// m_ channel: m_tdata holds check byte X in bits 15..8 and Y in bits 7..0.
// The cfg channel writes the 16-bit offset of the two check-byte positions,
// which are summed as zero; cfg_ready is always high.
// m_tvalid rises once a last byte has passed through the queue, the
// product stage and the output register. Throughput is one byte per
// cycle while the queue has room, and up to one check word per cycle.
// When the receiver stalls, finished words wait in the output register,
// the product stage and a two-entry queue; bytes keep flowing until the
// queue fills, then s_tready drops.
// Reset clears the sums, the byte count and all valid flags, and sets the
// offset to 14.
module iso_fletcher_checkbyte_generator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] check_word
);

    logic             q_room, q_push, q_pop, q_valid;
    fcgen_pkg::sums_t q_in, q_out;

    // Front: accepts bytes and accumulates the two sums.
    fcgen_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_room    (q_room),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    // Queue of finished message summaries.
    fcgen_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_in),
        .room       (q_room),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_out)
    );

    // Back: turns a summary into the check word.
    fcgen_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

endmodule
